FILE: sv/hfls_pkg.sv
// shared types, codes and log-sum correction table of the forward score unit
package hfls_pkg;

    localparam logic [1:0] FN_TRANS = 2'd0;
    localparam logic [1:0] FN_EMIT  = 2'd1;
    localparam logic [1:0] FN_OBS   = 2'd2;

    typedef enum logic [0:0] {
        OP_ADD = 1'b0,
        OP_LSE = 1'b1
    } alu_op_t;

    localparam int LUT_LEN = 50;

    localparam logic [7:0] LSE_LUT [LUT_LEN] = '{
        8'd177, 8'd162, 8'd147, 8'd134, 8'd121, 8'd110, 8'd99, 8'd89, 8'd80, 8'd72,
        8'd64,  8'd58,  8'd52,  8'd46,  8'd41,  8'd37,  8'd32, 8'd29, 8'd26, 8'd23,
        8'd20,  8'd18,  8'd16,  8'd14,  8'd12,  8'd11,  8'd10, 8'd9,  8'd8,  8'd7,
        8'd6,   8'd5,   8'd5,   8'd4,   8'd4,   8'd3,   8'd3,  8'd2,  8'd2,  8'd2,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,  8'd1,  8'd1,  8'd1
    };

endpackage

FILE: sv/hfls_alu.sv
// shared log-domain add and log-sum unit with saturation
module hfls_alu import hfls_pkg::*; #(
    parameter int VW = 16
) (
    input  alu_op_t             op,
    input  logic signed [VW-1:0] a,
    input  logic signed [VW-1:0] b,
    output logic signed [VW-1:0] y,
    output logic                 sat
);

    localparam logic signed [VW-1:0] NEG_INF = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX    = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW:0]   SMAX    = {2'b00, {(VW-1){1'b1}}};
    localparam logic signed [VW:0]   SMIN    = {2'b11, {(VW-2){1'b0}}, 1'b1};

    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] lo;
    logic signed [VW:0]   diff;
    logic [VW:0]          dsh;
    logic [7:0]           bump;
    logic signed [VW-1:0] base;
    logic signed [VW-1:0] addend;
    logic signed [VW:0]   sum;

    always_comb begin
        hi     = (a > b) ? a : b;
        lo     = (a > b) ? b : a;
        diff   = {hi[VW-1], hi} - {lo[VW-1], lo};
        dsh    = $unsigned(diff) >> 5;
        bump   = (dsh < (VW+1)'(LUT_LEN)) ? LSE_LUT[dsh[5:0]] : 8'd0;
        if (op == OP_ADD) begin
            base   = a;
            addend = b;
        end else begin
            base   = hi;
            addend = VW'($signed({1'b0, bump}));
        end
        sum = {base[VW-1], base} + {addend[VW-1], addend};
        sat = 1'b0;
        if (sum > SMAX) begin
            y   = VMAX;
            sat = 1'b1;
        end else if (sum < SMIN) begin
            y   = NEG_INF + VW'(1);
            sat = 1'b1;
        end else begin
            y = sum[VW-1:0];
        end
        if (a == NEG_INF || b == NEG_INF) begin
            sat = 1'b0;
            if (op == OP_ADD) begin
                y = NEG_INF;
            end else begin
                y = (a == NEG_INF) ? b : a;
            end
        end
    end

endmodule

FILE: sv/hmm_forward_log_score_unit.sv
// top level: hmm forward score in log space on one shared log-sum unit
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+-------------------
//  s_      | func row col log_value symbol last      | in  | s_valid / s_ready
//  m_      | score saturated                         | out | m_valid / m_ready
//  cfg_    | we wdata (states_in_use)                | in  | write on cfg_we
//
// table load beats are taken in idle only; a first symbol and each later symbol
// run state by state on the single alu and the one-read-per-cycle table
// memories. the last symbol adds the end-transition scan and final log-sum.
// reset is synchronous, clears control only; a waiting result beat holds the
// final step but not table loads.
module hmm_forward_log_score_unit import hfls_pkg::*; #(
    parameter int NSTATES     = 8,
    parameter int NRES        = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [3:0]         s_row,
    input  logic [4:0]         s_col,
    input  logic signed [15:0] s_log_value,
    input  logic [4:0]         s_symbol,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_score,
    output logic               m_saturated
);

    localparam int VW  = VALUE_WIDTH;
    localparam int TD  = NSTATES + 1;
    localparam int TN  = TD * TD;
    localparam int EN  = NSTATES * NRES;
    localparam int CN  = 2 * NSTATES;
    localparam int TAW = $clog2(TN);
    localparam int EAW = $clog2(EN);
    localparam int CAW = $clog2(CN);
    localparam int KW  = $clog2(NSTATES + 1);
    localparam int NRST = (NSTATES > 15) ? 15 : NSTATES;

    localparam logic signed [VW-1:0] NEG_INF = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX    = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [32:0]   VMAX_W  = 33'((64'sd1 <<< (VW-1)) - 64'sd1);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_F_RD  = 14'b00000000000010,
        ST_F_ADD = 14'b00000000000100,
        ST_L_RD  = 14'b00000000001000,
        ST_L_ADD = 14'b00000000010000,
        ST_L_ACC = 14'b00000000100000,
        ST_L_EMI = 14'b00000001000000,
        ST_X_RD  = 14'b00000010000000,
        ST_X_CHK = 14'b00000100000000,
        ST_S_RD  = 14'b00001000000000,
        ST_S_ADD = 14'b00010000000000,
        ST_S_ACC = 14'b00100000000000,
        ST_DONE  = 14'b01000000000000,
        ST_SPARE = 14'b10000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [KW-1:0]        l_reg, l_next;
    logic [KW-1:0]        n_reg, n_next;
    logic [3:0]           cfg_n_reg;
    logic                 cb_reg, cb_next;
    logic                 in_seq_reg, in_seq_next;
    logic                 sat_reg, sat_next;
    logic                 any_end_reg, any_end_next;
    logic                 last_reg, last_next;
    logic [4:0]           sym_reg, sym_next;
    logic                 oob_reg, oob_next;
    logic signed [VW-1:0] acc_reg, acc_next;
    logic signed [VW-1:0] term_reg, term_next;
    logic                 m_valid_reg;
    logic signed [15:0]   m_score_reg;
    logic                 m_sat_reg;

    logic signed [VW-1:0] tmem [TN];
    logic signed [VW-1:0] emem [EN];
    logic signed [VW-1:0] cmem [CN];
    logic signed [VW-1:0] t_q, e_q, c_q, e_eff;
    logic [TAW-1:0]       t_raddr, t_waddr;
    logic [EAW-1:0]       e_raddr, e_waddr;
    logic [CAW-1:0]       c_raddr, c_waddr;
    logic [KW:0]          t_r, t_c;
    logic [KW-1:0]        e_st, c_k;
    logic                 c_we;
    logic                 accept, t_we, e_we, out_free, k_end, l_end;
    logic signed [32:0]   ext_val, sc_w;
    logic signed [VW-1:0] in_val;
    logic [KW-1:0]        n_eff;

    alu_op_t              alu_op;
    logic signed [VW-1:0] alu_a, alu_b, alu_y;
    logic                 alu_sat, alu_use;

    hfls_alu #(.VW(VW)) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y),
        .sat (alu_sat)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_score     = m_score_reg;
    assign m_saturated = m_sat_reg;
    assign out_free    = !m_valid_reg || m_ready;
    assign k_end       = (k_reg == KW'(n_reg - 1'b1));
    assign l_end       = (l_reg == KW'(n_reg - 1'b1));
    assign e_eff       = oob_reg ? NEG_INF : e_q;

    // load value into the internal format
    always_comb begin
        ext_val = 33'(s_log_value);
        if (s_log_value == 16'sh8000) begin
            in_val = NEG_INF;
        end else if (ext_val > VMAX_W) begin
            in_val = VMAX;
        end else if (ext_val < -VMAX_W) begin
            in_val = NEG_INF + VW'(1);
        end else begin
            in_val = VW'(ext_val);
        end
    end

    always_comb begin
        if (cfg_n_reg == 4'd0) begin
            n_eff = KW'(1);
        end else if (int'(cfg_n_reg) > NSTATES) begin
            n_eff = KW'(NSTATES);
        end else begin
            n_eff = KW'(cfg_n_reg);
        end
    end

    assign t_we    = accept && (s_func == FN_TRANS) &&
                     int'(s_row) <= NSTATES && int'(s_col) <= NSTATES;
    assign e_we    = accept && (s_func == FN_EMIT) &&
                     int'(s_row) < NSTATES && int'(s_col) < NRES;
    assign t_waddr = TAW'(int'(s_row) * TD + int'(s_col));
    assign e_waddr = EAW'(int'(s_row) * NRES + int'(s_col));

    // read address generation
    always_comb begin
        t_r  = '0;
        t_c  = '0;
        e_st = k_reg;
        c_k  = k_reg;
        case (state_reg)
            ST_F_RD: begin
                t_c = (KW+1)'(k_reg) + 1'b1;
            end
            ST_L_RD: begin
                t_r = (KW+1)'(k_reg) + 1'b1;
                t_c = (KW+1)'(l_reg) + 1'b1;
            end
            ST_L_ACC: begin
                t_r  = (KW+1)'(k_reg) + (KW+1)'(2);
                t_c  = (KW+1)'(l_reg) + 1'b1;
                e_st = l_reg;
                c_k  = KW'(k_reg + 1'b1);
            end
            ST_X_RD, ST_S_RD: begin
                t_r = (KW+1)'(k_reg) + 1'b1;
            end
            default: begin
            end
        endcase
        t_raddr = TAW'(int'(t_r) * TD + int'(t_c));
        e_raddr = EAW'(int'(e_st) * NRES + int'(sym_reg));
        c_raddr = CAW'(int'(cb_reg) * NSTATES + int'(c_k));
    end

    always_ff @(posedge aclk) begin
        if (t_we) begin
            tmem[t_waddr] <= in_val;
        end
        t_q <= tmem[t_raddr];
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            emem[e_waddr] <= in_val;
        end
        e_q <= emem[e_raddr];
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            cmem[c_waddr] <= alu_y;
        end
        c_q <= cmem[c_raddr];
    end

    // alu operand selection
    always_comb begin
        alu_op  = OP_ADD;
        alu_a   = c_q;
        alu_b   = t_q;
        alu_use = 1'b0;
        case (state_reg)
            ST_F_ADD: begin
                alu_a   = e_eff;
                alu_use = 1'b1;
            end
            ST_L_ADD: begin
                alu_use = 1'b1;
            end
            ST_L_ACC, ST_S_ACC: begin
                alu_op  = OP_LSE;
                alu_a   = acc_reg;
                alu_b   = term_reg;
                alu_use = (k_reg != '0);
            end
            ST_L_EMI: begin
                alu_a   = e_eff;
                alu_b   = acc_reg;
                alu_use = 1'b1;
            end
            ST_S_ADD: begin
                alu_b   = any_end_reg ? t_q : '0;
                alu_use = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        n_next       = n_reg;
        cb_next      = cb_reg;
        in_seq_next  = in_seq_reg;
        sat_next     = sat_reg || (alu_use && alu_sat);
        any_end_next = any_end_reg;
        last_next    = last_reg;
        sym_next     = sym_reg;
        oob_next     = oob_reg;
        acc_next     = acc_reg;
        term_next    = term_reg;
        c_we         = 1'b0;
        c_waddr      = CAW'(int'(cb_reg) * NSTATES + int'(k_reg));
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_func == FN_OBS) begin
                    n_next    = n_eff;
                    sym_next  = s_symbol;
                    oob_next  = int'(s_symbol) >= NRES;
                    last_next = s_last;
                    k_next    = '0;
                    l_next    = '0;
                    if (!in_seq_reg) begin
                        sat_next   = 1'b0;
                        state_next = ST_F_RD;
                    end else begin
                        state_next = ST_L_RD;
                    end
                end
            end
            ST_F_RD: begin
                state_next = ST_F_ADD;
            end
            ST_F_ADD: begin
                c_we = 1'b1;
                if (k_end) begin
                    k_next       = '0;
                    in_seq_next  = 1'b1;
                    any_end_next = 1'b0;
                    state_next   = last_reg ? ST_X_RD : ST_IDLE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_F_RD;
                end
            end
            ST_L_RD: begin
                state_next = ST_L_ADD;
            end
            ST_L_ADD: begin
                term_next  = alu_y;
                state_next = ST_L_ACC;
            end
            ST_L_ACC: begin
                acc_next = (k_reg == '0) ? term_reg : alu_y;
                if (k_end) begin
                    state_next = ST_L_EMI;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_L_ADD;
                end
            end
            ST_L_EMI: begin
                c_we    = 1'b1;
                c_waddr = CAW'(int'(!cb_reg) * NSTATES + int'(l_reg));
                k_next  = '0;
                if (l_end) begin
                    l_next       = '0;
                    cb_next      = !cb_reg;
                    any_end_next = 1'b0;
                    state_next   = last_reg ? ST_X_RD : ST_IDLE;
                end else begin
                    l_next     = l_reg + 1'b1;
                    state_next = ST_L_RD;
                end
            end
            ST_X_RD: begin
                state_next = ST_X_CHK;
            end
            ST_X_CHK: begin
                if (t_q != NEG_INF) begin
                    any_end_next = 1'b1;
                end
                if (k_end) begin
                    k_next     = '0;
                    state_next = ST_S_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_X_RD;
                end
            end
            ST_S_RD: begin
                state_next = ST_S_ADD;
            end
            ST_S_ADD: begin
                term_next  = alu_y;
                state_next = ST_S_ACC;
            end
            ST_S_ACC: begin
                acc_next = (k_reg == '0) ? term_reg : alu_y;
                if (k_end) begin
                    state_next = ST_DONE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    in_seq_next = 1'b0;
                    k_next      = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // final score into the output format
    always_comb begin
        sc_w = 33'(acc_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            l_reg       <= '0;
            n_reg       <= KW'(NSTATES);
            cb_reg      <= 1'b0;
            in_seq_reg  <= 1'b0;
            sat_reg     <= 1'b0;
            any_end_reg <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            cfg_n_reg   <= 4'(NRST);
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            l_reg       <= l_next;
            n_reg       <= n_next;
            cb_reg      <= cb_next;
            in_seq_reg  <= in_seq_next;
            sat_reg     <= sat_next;
            any_end_reg <= any_end_next;
            last_reg    <= last_next;
            if (cfg_we) begin
                cfg_n_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg  <= sym_next;
        oob_reg  <= oob_next;
        acc_reg  <= acc_next;
        term_reg <= term_next;
        if (state_reg == ST_DONE && out_free) begin
            m_sat_reg <= sat_reg;
            if (acc_reg == NEG_INF) begin
                m_score_reg <= 16'sh8000;
            end else if (sc_w > 33'sd32767) begin
                m_score_reg <= 16'sd32767;
            end else if (sc_w < -33'sd32767) begin
                m_score_reg <= -16'sd32767;
            end else begin
                m_score_reg <= sc_w[15:0];
            end
        end
    end

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("finished score not presented");

    a_new_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == FN_OBS && !in_seq_reg) |=> (state_reg == ST_F_RD && !sat_reg))
        else $error("new sequence did not start cleanly");

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (k_reg < n_reg && l_reg < n_reg))
        else $error("state counter beyond states in use");

    a_seq_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> !in_seq_reg)
        else $error("sequence flag kept after score");

endmodule

FILE: bench/tb_hmm_forward_log_score_unit.sv
// testbench of the hmm forward score unit: self-checking against a built-in predictor
module tb_hmm_forward_log_score_unit;
    import hfls_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NST = 8;
    localparam int NRS = 32;
    localparam int TD = NST + 1;
    localparam longint VMX = 32767;
    localparam longint NINF = -32768;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [15:0] score;
        logic               saturated;
    } score_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic [3:0] s_row = '0;
    logic [4:0] s_col = '0;
    logic signed [15:0] s_log_value = '0;
    logic [4:0] s_symbol = '0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_score;
    logic m_saturated;

    longint trans_mem [TD*TD];
    longint emis_mem [NST*NRS];
    longint fwd_col [NST];
    longint nxt_col [NST];
    bit in_seq;
    bit sat_seen;
    int unsigned states_cfg;

    score_beat_t score_q [$];
    int unsigned fails = 0;
    int unsigned sent = 0;
    int unsigned burst_left = 0;
    bit stall_off = 1'b0;

    always #6 aclk = ~aclk;

    hmm_forward_log_score_unit DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_row(s_row),
        .s_col(s_col), .s_log_value(s_log_value), .s_symbol(s_symbol), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_score(m_score),
        .m_saturated(m_saturated)
    );

    function automatic longint clampf(longint v);
        if (v > VMX) begin
            sat_seen = 1'b1;
            return VMX;
        end
        if (v < NINF + 1) begin
            sat_seen = 1'b1;
            return NINF + 1;
        end
        return v;
    endfunction

    function automatic longint lg_add(longint a, longint b);
        if (a == NINF || b == NINF) return NINF;
        return clampf(a + b);
    endfunction

    function automatic longint lg_sum(longint acc, longint x);
        longint hi, lo, d;
        if (acc == NINF) return x;
        if (x == NINF) return acc;
        hi = acc > x ? acc : x;
        lo = acc > x ? x : acc;
        d = (hi - lo) >>> 5;
        if (d < LUT_LEN) return clampf(hi + longint'(LSE_LUT[d]));
        return hi;
    endfunction

    task automatic forward_predict(logic [1:0] fn, logic [3:0] r, logic [4:0] c,
                                   logic signed [15:0] lv, logic [4:0] sym, logic lst);
        longint v, acc, sc, endv;
        int unsigned n;
        bit any_end;
        score_beat_t b;
        v = longint'(lv);
        if (fn == FN_TRANS) begin
            if (r <= NST && c <= NST) trans_mem[r*TD + c] = v;
        end else if (fn == FN_EMIT) begin
            if (r < NST && c < NRS) emis_mem[r*NRS + c] = v;
        end else if (fn == FN_OBS) begin
            n = states_cfg < 1 ? 1 : (states_cfg > NST ? NST : states_cfg);
            if (!in_seq) begin
                sat_seen = 1'b0;
                for (int k = 0; k < n; k++)
                    fwd_col[k] = lg_add(emis_mem[k*NRS + sym], trans_mem[k+1]);
                in_seq = 1'b1;
            end else begin
                for (int l = 0; l < n; l++) begin
                    acc = lg_add(fwd_col[0], trans_mem[TD + l + 1]);
                    for (int k = 1; k < n; k++)
                        acc = lg_sum(acc, lg_add(fwd_col[k], trans_mem[(k+1)*TD + l + 1]));
                    nxt_col[l] = lg_add(emis_mem[l*NRS + sym], acc);
                end
                for (int l = 0; l < n; l++) fwd_col[l] = nxt_col[l];
            end
            if (lst) begin
                any_end = 1'b0;
                for (int k = 0; k < n; k++)
                    if (trans_mem[(k+1)*TD] != NINF) any_end = 1'b1;
                sc = NINF;
                for (int k = 0; k < n; k++) begin
                    endv = any_end ? trans_mem[(k+1)*TD] : 0;
                    if (k == 0) sc = lg_add(fwd_col[0], endv);
                    else sc = lg_sum(sc, lg_add(fwd_col[k], endv));
                end
                if (sc != NINF && sc < -32767) sc = -32767;
                b.score = 16'(sc);
                b.saturated = sat_seen;
                score_q.push_back(b);
                in_seq = 1'b0;
            end
        end
    endtask

    task automatic send_beat(logic [1:0] fn, logic [3:0] r, logic [4:0] c,
                             logic signed [15:0] lv, logic [4:0] sym, logic lst);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_func <= fn;
        s_row <= r;
        s_col <= c;
        s_log_value <= lv;
        s_symbol <= sym;
        s_last <= lst;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        forward_predict(fn, r, c, lv, sym, lst);
        sent++;
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 11))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd32767;
            3: return 16'($urandom);
            4: return 16'($urandom_range(0, 2000));
            default: return -16'($urandom_range(0, 3000));
        endcase
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (score_q.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
    endtask

    task automatic set_states(logic [3:0] n);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_we <= 1'b0;
        states_cfg = n;
    endtask

    task automatic load_tables();
        for (int r = 0; r < TD; r++)
            for (int c = 0; c < TD; c++)
                send_beat(FN_TRANS, 4'(r), 5'(c), pick_value(), 5'($urandom), 1'($urandom));
        for (int r = 0; r < NST; r++)
            for (int c = 0; c < NRS; c++)
                send_beat(FN_EMIT, 4'(r), 5'(c), pick_value(), 5'($urandom), 1'($urandom));
    endtask

    task automatic run_sequence(int unsigned len);
        for (int i = 1; i <= len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(FN_TRANS, 4'($urandom_range(0, 8)), 5'($urandom_range(0, 8)),
                          pick_value(), 5'($urandom), 1'b0);
            send_beat(FN_OBS, 4'($urandom), 5'($urandom), 16'($urandom),
                      5'($urandom), i == len);
        end
    endtask

    task automatic test_directed();
        send_beat(FN_OBS, 4'd0, 5'd0, 16'sd0, 5'd0, 1'b1);
        send_beat(FN_OBS, 4'hf, 5'h1f, 16'sd0, 5'd31, 1'b1);
        send_beat(FN_UNUSED, 4'hf, 5'h1f, -16'sd1, 5'd31, 1'b1);
        send_beat(FN_TRANS, 4'd9, 5'd3, 16'sd5, 5'd0, 1'b0);
        send_beat(FN_TRANS, 4'd2, 5'd9, 16'sd5, 5'd0, 1'b0);
        send_beat(FN_EMIT, 4'd8, 5'd3, 16'sd5, 5'd0, 1'b0);
        send_beat(FN_EMIT, 4'hf, 5'h1f, 16'sd5, 5'd0, 1'b0);
        for (int k = 1; k <= NST; k++)
            send_beat(FN_TRANS, 4'(k), 5'd0, -16'sd32768, 5'd0, 1'b0);
        run_sequence(3);
        send_beat(FN_TRANS, 4'd1, 5'd1, 16'sd32767, 5'd0, 1'b0);
        send_beat(FN_EMIT, 4'd0, 5'd4, 16'sd32767, 5'd0, 1'b0);
        send_beat(FN_OBS, 4'd0, 5'd0, 16'sd0, 5'd4, 1'b0);
        send_beat(FN_EMIT, 4'd0, 5'd4, -16'sd32767, 5'd0, 1'b0);
        send_beat(FN_OBS, 4'd0, 5'd0, 16'sd0, 5'd4, 1'b1);
        for (int k = 1; k <= NST; k++)
            send_beat(FN_TRANS, 4'(k), 5'd0, pick_value(), 5'd0, 1'b0);
    endtask

    task automatic test_config_extremes();
        set_states(4'd1);
        run_sequence(2);
        set_states(4'd0);
        run_sequence(3);
        set_states(4'd15);
        run_sequence(2);
        set_states(4'd8);
        run_sequence(4);
    endtask

    task automatic test_random();
        int unsigned next_cfg;
        next_cfg = sent + 300;
        while (sent < 1350) begin
            if (sent >= next_cfg) begin
                set_states(4'($urandom_range(0, 15)));
                stall_off = $urandom_range(0, 2) == 0;
                next_cfg = sent + 300;
            end
            case ($urandom_range(0, 19))
                0, 1: send_beat(FN_TRANS, 4'($urandom_range(0, 8)), 5'($urandom_range(0, 8)),
                                pick_value(), 5'($urandom), 1'($urandom));
                2, 3: send_beat(FN_EMIT, 4'($urandom_range(0, 7)), 5'($urandom),
                                pick_value(), 5'($urandom), 1'($urandom));
                4: send_beat(FN_UNUSED, 4'($urandom), 5'($urandom), 16'($urandom),
                             5'($urandom), 1'($urandom));
                5: send_beat(FN_TRANS, 4'($urandom_range(9, 15)), 5'($urandom),
                             16'($urandom), 5'($urandom), 1'($urandom));
                6: send_beat(FN_EMIT, 4'($urandom_range(8, 15)), 5'($urandom),
                             16'($urandom), 5'($urandom), 1'($urandom));
                default: run_sequence($urandom_range(1, 5));
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn || stall_off) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= ~m_ready;
        end
    end

    always @(posedge aclk) begin
        score_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (score_q.size() == 0) begin
                $display("%0t unexpected score beat: expected none, got %0d/%0b",
                         $time, m_score, m_saturated);
                fails++;
            end else begin
                e = score_q.pop_front();
                if (m_score !== e.score) begin
                    $display("%0t score mismatch: expected %0d, got %0d",
                             $time, e.score, m_score);
                    fails++;
                end
                if (m_saturated !== e.saturated) begin
                    $display("%0t saturated mismatch: expected %0b, got %0b",
                             $time, e.saturated, m_saturated);
                    fails++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("hmm_forward_log_score_unit regression: fail");
        $finish;
    end

    initial begin
        for (int i = 0; i < TD*TD; i++) trans_mem[i] = 0;
        for (int i = 0; i < NST*NRS; i++) emis_mem[i] = 0;
        for (int i = 0; i < NST; i++) begin
            fwd_col[i] = 0;
            nxt_col[i] = 0;
        end
        in_seq = 1'b0;
        sat_seen = 1'b0;
        states_cfg = NST;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_tables();
        test_directed();
        test_config_extremes();
        test_random();
        s_valid <= 1'b0;
        while (score_q.size() != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
        if (fails == 0 && score_q.size() == 0) begin
            $display("hmm_forward_log_score_unit regression: pass");
        end else begin
            $display("hmm_forward_log_score_unit regression: fail");
        end
        $finish;
    end
endmodule
